// ===== hdl/ccs_pkg.sv =====
package ccs_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned WORK_W    = 14;
  localparam logic [WORK_W-1:0] WORK_MAX  = {WORK_W{1'b1}};
  localparam logic [2:0]        CMP_COST  = 3'd1;
  localparam logic [2:0]        SWAP_COST = 3'd3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [WORK_W-1:0]        work_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CHK,
    S_CMP,
    S_SWAP,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

endpackage

// ===== hdl/ccs_if.sv =====
interface ccs_in_if import ccs_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value;
  logic  last_in;

  modport source (output valid, value, last_in, input ready);
  modport sink (input valid, value, last_in, output ready);
endinterface

interface ccs_out_if import ccs_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  last_out;
  work_t work_count;

  modport source (output valid, sorted_value, last_out, work_count, input ready);
  modport sink (input valid, sorted_value, last_out, work_count, output ready);
endinterface

// ===== hdl/cocktail_shaker_sort_with_work_count.sv =====
// Collects up to MAX_ELEMENTS signed 32-bit values, one per request, until a
// request flagged last_in (or the one that fills the store), then sorts them
// ascending by cocktail shaker sort and returns them in order, the final one
// flagged, each carrying the work count (one per comparison, three more per
// swap, saturating at 16383). The sort runs one compare unit over a single
// element memory with two read ports and one write port: S_CHK reads a pair,
// S_CMP compares it and writes the lower slot of a swap, S_SWAP the upper.
// Each result is read in S_EMIT_RD and held in S_EMIT_OUT until taken. No
// request is taken from the closing element until the last result leaves.
module cocktail_shaker_sort_with_work_count
  import ccs_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  ccs_in_if.sink        in_req,
  ccs_out_if.source     out_res
);

  localparam int unsigned IDX_W = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  data_t mem [MAX_ELEMENTS];

  state_t state_r, state_nxt;
  cnt_t   count_r, count_nxt;
  idx_t   left_r, left_nxt;
  idx_t   right_r, right_nxt;
  idx_t   lsp_r, lsp_nxt;
  idx_t   j_r, j_nxt;
  idx_t   k_r, k_nxt;
  logic   fwd_r, fwd_nxt;
  work_t  work_r, work_nxt;
  data_t  rd_a_r, rd_b_r;

  logic   mem_we;
  idx_t   mem_waddr;
  data_t  mem_wdata;
  logic   rd_en;
  idx_t   rd_addr_a, rd_addr_b;

  idx_t   lo_idx, hi_idx, j_step;
  logic   swap_hit, emit_last, load_done;
  logic [WORK_W:0] work_sum;

  assign lo_idx    = fwd_r ? j_r : j_r - idx_t'(1);
  assign hi_idx    = lo_idx + idx_t'(1);
  assign j_step    = fwd_r ? j_r + idx_t'(1) : j_r - idx_t'(1);
  assign swap_hit  = rd_a_r > rd_b_r;
  assign work_sum  = {1'b0, work_r} + (WORK_W + 1)'(swap_hit ? CMP_COST + SWAP_COST : CMP_COST);
  assign emit_last = (cnt_t'({1'b0, k_r}) + cnt_t'(1)) == count_r;
  assign load_done = in_req.last_in || (count_r == cnt_t'(MAX_ELEMENTS - 1));

  assign in_req.ready         = (state_r == S_LOAD);
  assign out_res.valid        = (state_r == S_EMIT_OUT);
  assign out_res.sorted_value = rd_a_r;
  assign out_res.last_out     = emit_last;
  assign out_res.work_count   = work_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      left_r  <= '0;
      right_r <= '0;
      lsp_r   <= '0;
      j_r     <= '0;
      k_r     <= '0;
      fwd_r   <= 1'b0;
      work_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      lsp_r   <= lsp_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      fwd_r   <= fwd_nxt;
      work_r  <= work_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    lsp_nxt   = lsp_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    fwd_nxt   = fwd_r;
    work_nxt  = work_r;
    mem_we    = 1'b0;
    mem_waddr = lo_idx;
    mem_wdata = rd_b_r;
    rd_en     = 1'b0;
    rd_addr_a = lo_idx;
    rd_addr_b = hi_idx;

    case (state_r)
      S_LOAD: begin
        mem_waddr = count_r[IDX_W-1:0];
        mem_wdata = in_req.value;
        if (in_req.valid) begin
          mem_we    = 1'b1;
          count_nxt = count_r + cnt_t'(1);
          if (load_done) begin
            work_nxt  = '0;
            left_nxt  = '0;
            right_nxt = count_r[IDX_W-1:0];
            lsp_nxt   = count_r[IDX_W-1:0];
            j_nxt     = count_r[IDX_W-1:0];
            fwd_nxt   = 1'b0;
            k_nxt     = '0;
            state_nxt = (count_r == '0) ? S_EMIT_RD : S_CHK;
          end
        end
      end

      S_CHK: begin
        if (!fwd_r) begin
          if (j_r > left_r) begin
            rd_en     = 1'b1;
            state_nxt = S_CMP;
          end else begin
            left_nxt = lsp_r;
            j_nxt    = lsp_r;
            fwd_nxt  = 1'b1;
          end
        end else begin
          if (j_r < right_r) begin
            rd_en     = 1'b1;
            state_nxt = S_CMP;
          end else begin
            right_nxt = lsp_r;
            if (left_r < lsp_r) begin
              j_nxt   = lsp_r;
              fwd_nxt = 1'b0;
            end else begin
              k_nxt     = '0;
              state_nxt = S_EMIT_RD;
            end
          end
        end
      end

      S_CMP: begin
        work_nxt = work_sum[WORK_W] ? WORK_MAX : work_sum[WORK_W-1:0];
        if (swap_hit) begin
          mem_we    = 1'b1;
          lsp_nxt   = j_r;
          state_nxt = S_SWAP;
        end else begin
          j_nxt     = j_step;
          state_nxt = S_CHK;
        end
      end

      S_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = hi_idx;
        mem_wdata = rd_a_r;
        j_nxt     = j_step;
        state_nxt = S_CHK;
      end

      S_EMIT_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = k_r;
        state_nxt = S_EMIT_OUT;
      end

      S_EMIT_OUT: begin
        if (out_res.ready) begin
          if (emit_last) begin
            count_nxt = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + idx_t'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> !out_res.valid)
    else $error("request taken while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(MAX_ELEMENTS))
    else $error("element count beyond store depth");

  a_back_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && !fwd_r) |-> j_r > left_r)
    else $error("backward compare outside unsorted bounds");

  a_fwd_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && fwd_r) |-> j_r < right_r)
    else $error("forward compare outside unsorted bounds");

  a_work_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_OUT && $past(state_r == S_EMIT_OUT)) |-> $stable(work_r))
    else $error("work count changed during emission");

  a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.ready && out_res.last_out) |=> in_req.ready)
    else $error("not ready for a new set after the final result");

endmodule
